[rtl/core/owpv_pkg.sv]
// ----------------------------------------------------------------------------
// Omni wheel PI velocity control package
// Shared types and constants for the omni wheel velocity controller.
// ----------------------------------------------------------------------------
`default_nettype none
package owpv_pkg;
	localparam int unsigned NumWheels = 3;
	localparam logic [16:0] Sin60Q16 = 17'd56756;

	typedef enum logic [2:0] {
		CFG_PROP_GAIN  = 3'd0,
		CFG_INTEG_GAIN = 3'd1,
		CFG_INTEG_LIM  = 3'd2,
		CFG_OUT_LIM    = 3'd3,
		CFG_WHEEL_SCL  = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DONE
	} mul_state_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_MIXA,
		PH_MIXB,
		PH_SCALE,
		PH_IGAIN,
		PH_PGAIN,
		PH_NEXT,
		PH_OUT
	} phase_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mul_ctl_t;
endpackage
`default_nettype wire

[rtl/core/owpv_serial_mul.sv]
// ----------------------------------------------------------------------------
// Bit-serial unsigned multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, 96-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module owpv_serial_mul (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [63:0]      op_a,
	input  wire logic [31:0]      op_b,
	output owpv_pkg::mul_ctl_t    ctl,
	output logic      [95:0]      product
);
	import owpv_pkg::*;

	mul_state_t state_q, state_d;
	logic [5:0]  cnt_q;
	logic [95:0] acc_q;
	logic [95:0] a_q;
	logic [31:0] b_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_MUL;
			ST_MUL:  if (cnt_q == 6'd31) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.start = start;
		ctl.busy  = (state_q == ST_MUL);
		ctl.done  = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) cnt_q <= cnt_q + 6'd1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			acc_q <= '0;
			a_q   <= {32'd0, op_a};
			b_q   <= op_b;
		end else if (state_q == ST_MUL) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[94:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign product = acc_q;
endmodule
`default_nettype wire

[rtl/core/omni_wheel_pi_velocity_control_core.sv]
// ----------------------------------------------------------------------------
// Omni wheel PI velocity control core
// Three-wheel kinematic mix, wheel scaling and per-wheel PI with clamps.
// ----------------------------------------------------------------------------
// One word is processed at a time. Per wheel the shared bit-serial multiplier
// runs up to five products (two mix terms, the wheel scale, the integral gain
// and the proportional gain), after a step that selects the wheel. The rear
// wheel needs only one mix product, and an unseen wheel is skipped. The result
// waits in an output register, and a new word is accepted once that result has
// been taken.
`default_nettype none
module omni_wheel_pi_velocity_control_core #(
	parameter int unsigned FRAC_BITS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// cmd_x[15:0], cmd_y[31:16], cmd_turn[47:32], meas_left[79:48],
	// meas_right[111:80], meas_rear[143:112], zero fill [151:144]
	input  wire logic [151:0] s_tdata,
	// seen_mask[2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// torque_left[15:0], torque_right[31:16], torque_rear[47:32]
	output logic [47:0]       m_tdata,
	// updated_mask[2:0]
	output logic [2:0]        m_tuser
);
	import owpv_pkg::*;

	localparam int unsigned IW = 16 + FRAC_BITS;
	localparam int unsigned Shr = 32 - FRAC_BITS;
	localparam logic [63:0] Cap = 64'h4000_0000_0000_0000;

	logic [31:0] prop_gain_q, integ_gain_q;
	logic [14:0] integ_lim_q, out_lim_q;
	logic [23:0] wheel_scale_q;

	phase_t      ph_q;
	logic [1:0]  wh_q;
	logic        busy_q;
	logic [47:0] cmd_q;
	logic [95:0] meas_q;
	logic [2:0]  seen_q;
	logic [IW-1:0] integ_q [NumWheels];
	logic signed [47:0] mix_q;
	logic        neg_q;
	logic [63:0] mag_q;
	logic signed [IW+1:0] acc_q;
	logic [47:0] torq_q;
	logic [2:0]  upd_q;
	logic        mpend_q;

	logic        mul_start;
	logic [63:0] mul_a;
	logic [31:0] mul_b;
	mul_ctl_t    mctl;
	logic [95:0] prod;

	owpv_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
		.ctl(mctl), .product(prod)
	);

	logic signed [15:0] cx, cy, ct;
	logic signed [31:0] mw;
	logic [63:0] psat, pshift;
	logic signed [64:0] gval;
	logic signed [IW+1:0] ilim, acc_c, out_c, olim;
	logic signed [65:0] asum, osum;
	logic signed [95:0] tgt_full;
	logic signed [63:0] err_c;
	logic signed [15:0] tq;
	logic [63:0] xmag;

	always_comb begin
		cx = cmd_q[15:0];
		cy = cmd_q[31:16];
		ct = cmd_q[47:32];
		unique case (wh_q)
			2'd0:    mw = meas_q[31:0];
			2'd1:    mw = meas_q[63:32];
			default: mw = meas_q[95:64];
		endcase
		psat   = (prod > {32'd0, Cap}) ? Cap : prod[63:0];
		pshift = psat >> Shr;
		gval   = neg_q ? -$signed({1'b0, pshift}) : $signed({1'b0, pshift});
		ilim   = $signed({3'b000, integ_lim_q, {FRAC_BITS{1'b0}}});
		olim   = $signed({3'b000, out_lim_q, {FRAC_BITS{1'b0}}});
		asum   = 66'($signed(integ_q[wh_q])) + 66'(gval);
		if (asum > 66'(ilim)) acc_c = ilim;
		else if (asum < -66'(ilim)) acc_c = -ilim;
		else acc_c = (IW+2)'(asum);
		osum   = 66'(acc_q) + 66'(gval);
		if (osum > 66'(olim)) out_c = olim;
		else if (osum < -66'(olim)) out_c = -olim;
		else out_c = (IW+2)'(osum);
		tq = 16'((out_c < 0) ? -((-out_c) >>> FRAC_BITS) : (out_c >>> FRAC_BITS));
		tgt_full = mix_q[47] ? -$signed(prod) : $signed(prod);
		err_c = 64'((tgt_full < 0) ? -((-tgt_full) >>> 16) : (tgt_full >>> 16))
			- 64'(mw) * 64'sd256;
		xmag = mix_q[47] ? 64'(-mix_q) : 64'(mix_q);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ph_q)
			PH_MIXA:  begin
				mul_a = 64'(cx[15] ? -32'(cx) : 32'(cx));
				mul_b = 32'd32768;
			end
			PH_MIXB:  begin
				mul_a = 64'(cy[15] ? -32'(cy) : 32'(cy));
				mul_b = 32'(Sin60Q16);
			end
			PH_SCALE: begin
				mul_a = xmag;
				mul_b = 32'(wheel_scale_q);
			end
			PH_IGAIN: begin
				mul_a = mag_q;
				mul_b = integ_gain_q;
			end
			PH_PGAIN: begin
				mul_a = mag_q;
				mul_b = prop_gain_q;
			end
			default: ;
		endcase
		mul_start = busy_q && !mpend_q && !mctl.busy && !mctl.done &&
			(ph_q == PH_MIXA || ph_q == PH_MIXB || ph_q == PH_SCALE ||
			 ph_q == PH_IGAIN || ph_q == PH_PGAIN);
	end

	assign s_tready = !busy_q && !(m_tvalid && !m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= 32'd125829;
			integ_gain_q  <= 32'd1678;
			integ_lim_q   <= 15'd700;
			out_lim_q     <= 15'd1000;
			wheel_scale_q <= 24'd116403;
			for (int i = 0; i < NumWheels; i++) integ_q[i] <= '0;
			ph_q     <= PH_IDLE;
			busy_q   <= 1'b0;
			m_tvalid <= 1'b0;
			mpend_q  <= 1'b0;
			wh_q     <= '0;
			mix_q    <= '0;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			acc_q    <= '0;
			torq_q   <= '0;
			upd_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PROP_GAIN:  prop_gain_q   <= cfg_data;
					CFG_INTEG_GAIN: integ_gain_q  <= cfg_data;
					CFG_INTEG_LIM:  integ_lim_q   <= cfg_data[14:0];
					CFG_OUT_LIM:    out_lim_q     <= cfg_data[14:0];
					CFG_WHEEL_SCL:  wheel_scale_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (ph_q == PH_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (mul_start) mpend_q <= 1'b1;
			if (mctl.done) mpend_q <= 1'b0;
			unique case (ph_q)
				PH_IDLE: if (s_tvalid && s_tready) begin
					busy_q <= 1'b1;
					wh_q   <= '0;
					torq_q <= '0;
					upd_q  <= '0;
					ph_q   <= PH_NEXT;
				end
				PH_NEXT: begin
					if (wh_q == 2'd3) ph_q <= PH_OUT;
					else if (seen_q[wh_q]) ph_q <= PH_MIXA;
					else wh_q <= wh_q + 2'd1;
				end
				PH_MIXA: if (mctl.done) begin
					if (wh_q == 2'd2) mix_q <= 48'(ct) * 48'sd65536 + 48'(cx) * 48'sd65536;
					else mix_q <= 48'(ct) * 48'sd65536 -
						(cx[15] ? -$signed(48'(prod[47:0])) : $signed(48'(prod[47:0])));
					ph_q <= (wh_q == 2'd2) ? PH_SCALE : PH_MIXB;
				end
				PH_MIXB: if (mctl.done) begin
					if ((wh_q == 2'd1) != cy[15]) mix_q <= mix_q + $signed(prod[47:0]);
					else mix_q <= mix_q - $signed(prod[47:0]);
					ph_q <= PH_SCALE;
				end
				PH_SCALE: if (mctl.done) begin
					neg_q <= err_c[63];
					mag_q <= err_c[63] ? 64'(-err_c) : 64'(err_c);
					ph_q  <= PH_IGAIN;
				end
				PH_IGAIN: if (mctl.done) begin
					acc_q <= acc_c;
					integ_q[wh_q] <= acc_c[IW-1:0];
					ph_q <= PH_PGAIN;
				end
				PH_PGAIN: if (mctl.done) begin
					torq_q[wh_q*16 +: 16] <= tq;
					upd_q[wh_q] <= 1'b1;
					wh_q <= wh_q + 2'd1;
					ph_q <= PH_NEXT;
				end
				PH_OUT: if (!m_tvalid || m_tready) begin
					busy_q   <= 1'b0;
					ph_q     <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && s_tvalid && s_tready) begin
			cmd_q  <= s_tdata[47:0];
			meas_q <= s_tdata[143:48];
			seen_q <= s_tuser;
		end
		if (ph_q == PH_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= torq_q;
			m_tuser <= upd_q;
		end
	end

	initial_guard_unused: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> mctl.busy) else $error("multiplier did not start");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready) else $error("ready while busy");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result lost");
endmodule
`default_nettype wire

[tb/owpv_checker.sv]
// ----------------------------------------------------------------------------
// Omni wheel PI velocity control checker
// Watches the input, output and register write channels, predicts each torque
// word from the command and the wheel state, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module owpv_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [151:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [47:0]  m_tdata,
	input  wire logic [2:0]   m_tuser,
	output int                errors,
	output int                pending
);
	import owpv_pkg::*;

	localparam int Frac = 24;

	typedef struct packed {
		logic [2:0]  mask;
		logic [47:0] torques;
	} torque_word_t;

	longint unsigned kp, ki, ilim, olim, wscale;
	longint integ [3];
	torque_word_t torque_q[$];

	assign pending = torque_q.size();

	function automatic longint gain_mul(longint unsigned mag, logic neg,
			longint unsigned g);
		longint unsigned cap, p;
		cap = 64'd1 << 62;
		if (g != 0 && mag > cap / g) p = cap;
		else p = mag * g;
		p = p >> (32 - Frac);
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clamp_lim(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	task automatic predict_torques(input logic [151:0] d, input logic [2:0] seen);
		longint x, y, t, tgt, err, acc, o, one;
		longint mix [3];
		longint meas [3];
		longint unsigned mag;
		torque_word_t w;
		one = longint'(1) << Frac;
		x = longint'(signed'(d[15:0]));
		y = longint'(signed'(d[31:16]));
		t = longint'(signed'(d[47:32]));
		meas[0] = longint'(signed'(d[79:48]));
		meas[1] = longint'(signed'(d[111:80]));
		meas[2] = longint'(signed'(d[143:112]));
		mix[0] = t * 65536 - x * 32768 - y * longint'(Sin60Q16);
		mix[1] = t * 65536 - x * 32768 + y * longint'(Sin60Q16);
		mix[2] = (t + x) * 65536;
		w = '0;
		for (int i = 0; i < 3; i++) begin
			if (seen[i]) begin
				tgt = (mix[i] * longint'(wscale)) / 65536;
				err = tgt - meas[i] * 256;
				mag = (err < 0) ? longint'(-err) : err;
				acc = clamp_lim(integ[i] + gain_mul(mag, err < 0, ki),
					longint'(ilim) * one);
				integ[i] = acc;
				o = clamp_lim(gain_mul(mag, err < 0, kp) + acc, longint'(olim) * one);
				o = o / one;
				w.torques[16*i +: 16] = o[15:0];
				w.mask[i] = 1'b1;
			end
		end
		torque_q.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		torque_word_t e;
		if (!arst_n) begin
			kp = 125829; ki = 1678; ilim = 700; olim = 1000; wscale = 116403;
			for (int i = 0; i < 3; i++) integ[i] = 0;
			torque_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROP_GAIN:  kp = cfg_data;
					CFG_INTEG_GAIN: ki = cfg_data;
					CFG_INTEG_LIM:  ilim = cfg_data[14:0];
					CFG_OUT_LIM:    olim = cfg_data[14:0];
					CFG_WHEEL_SCL:  wscale = cfg_data[23:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (torque_q.size() == 0) begin
					report_mismatch("unexpected word", m_tdata[15:0], 0);
				end else begin
					e = torque_q.pop_front();
					if (m_tuser !== e.mask) report_mismatch("updated_mask", m_tuser, e.mask);
					for (int i = 0; i < 3; i++)
						if (m_tdata[16*i +: 16] !== e.torques[16*i +: 16])
							report_mismatch($sformatf("torque %0d", i),
								signed'(m_tdata[16*i +: 16]),
								signed'(e.torques[16*i +: 16]));
				end
			end
			if (s_tvalid && s_tready) predict_torques(s_tdata, s_tuser);
		end
	end
endmodule
`default_nettype wire

[tb/tb_omni_wheel_pi_velocity_control_core.sv]
// ----------------------------------------------------------------------------
// Omni wheel PI velocity control testbench
// Drives directed and random velocity commands through several register
// settings, with random gaps, stalls and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_omni_wheel_pi_velocity_control_core;
	import owpv_pkg::*;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 0, s_tready;
	logic [151:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid, m_tready = 0;
	logic [47:0] m_tdata;
	logic [2:0] m_tuser;
	int errors, pending;
	int cycles = 0;
	bit calm = 0, hold_off = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	omni_wheel_pi_velocity_control_core DUT (.*);
	owpv_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off) m_tready <= 0;
		else m_tready <= calm || ($urandom_range(99) >= 8);
	end

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_word(input logic [15:0] x, y, t, input logic [31:0] l, r, b,
			input logic [2:0] seen);
		while (!calm && $urandom_range(99) < 8) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {8'h00, b, r, l, t, y, x};
		s_tuser <= seen;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (700) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_meas();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(4000)) - 2000);
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	task automatic random_words(input int n);
		for (int i = 0; i < n; i++)
			send_word($urandom, $urandom, $urandom, rand_meas(), rand_meas(), rand_meas(),
				$urandom_range(7));
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1;
		send_word(16'h7fff, 16'h7fff, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff, 0, 3'b111);
		send_word(16'h8000, 16'h8000, 16'h8000, 32'h7fff_ffff, 32'h8000_0000, 0, 3'b111);
		send_word(0, 0, 0, 0, 0, 0, 3'b000);
		send_word(100, -200, 50, 1000, -1000, 5, 3'b101);
		send_word(-1, 1, 0, -1, 1, 32'hffff_ffff, 3'b010);
		for (int i = 0; i < 8; i++) send_word(300, 300, 300, 0, 0, 0, 3'b111);
		drain();
		write_reg(CFG_PROP_GAIN, 32'hffff_ffff);
		write_reg(CFG_INTEG_GAIN, 32'hffff_ffff);
		write_reg(CFG_INTEG_LIM, 32'h7fff);
		write_reg(CFG_OUT_LIM, 32'h7fff);
		write_reg(CFG_WHEEL_SCL, 32'hff_ffff);
		send_word(16'h7fff, 16'h8000, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff, 1, 3'b111);
		send_word(5, 5, 5, 0, 0, 0, 3'b111);
		drain();
		write_reg(cfg_index_t'(3'd7), 32'h1234);
		random_words(200);
		drain();
		write_reg(CFG_PROP_GAIN, 0);
		write_reg(CFG_INTEG_GAIN, 0);
		write_reg(CFG_INTEG_LIM, 0);
		write_reg(CFG_OUT_LIM, 0);
		write_reg(CFG_WHEEL_SCL, 0);
		random_words(100);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_PROP_GAIN, $urandom_range(4000000));
			write_reg(CFG_INTEG_GAIN, $urandom_range(400000));
			write_reg(CFG_INTEG_LIM, $urandom_range(32767));
			write_reg(CFG_OUT_LIM, $urandom_range(32767));
			write_reg(CFG_WHEEL_SCL, $urandom_range(16777215));
			if (ph == 1) calm = 1;
			if (ph == 2) begin
				calm = 0;
				fork
					begin
						hold_off = 1;
						for (int c = 0; c < 4000; c++) @(negedge clk);
						hold_off = 0;
					end
				join_none
			end
			random_words(225);
			drain();
		end
		drain();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
rtl/core/owpv_pkg.sv
rtl/core/owpv_serial_mul.sv
rtl/core/omni_wheel_pi_velocity_control_core.sv
tb/owpv_checker.sv
tb/tb_omni_wheel_pi_velocity_control_core.sv
